// ===== rtl/core/sfr_pkg.sv =====
`timescale 1ns / 1ps
// sfr_pkg: shared constants, codes and the front-to-back command type
// of the spike fan-out router. No dependencies.

package sfr_pkg;

    localparam int MAX_PRE    = 1024;
    localparam int MAX_CONN   = 4096;
    localparam int MAX_FANOUT = 64;
    localparam int ID_BITS    = 24;

    localparam int PRE_AW      = $clog2(MAX_PRE);
    localparam int OFF_AW      = $clog2(MAX_PRE + 1);
    localparam int CONN_AW     = $clog2(MAX_CONN);
    localparam int FANOUT_W    = $clog2(MAX_FANOUT + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ACT_LOAD_PRE  = 2'd0;
    localparam logic [1:0] ACT_LOAD_CONN = 2'd1;
    localparam logic [1:0] ACT_SPIKE     = 2'd2;
    localparam logic [1:0] ACT_START     = 2'd3;

    localparam logic [1:0] CFG_PRE_COUNT    = 2'd0;
    localparam logic [1:0] CFG_STEPS_PER_MS = 2'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [CONN_AW-1:0]  addr;
        logic [15:0]         target;
        logic [15:0]         delay;
        logic [FANOUT_W-1:0] count;
        logic                trunc;
        logic signed [8:0]   base;
    } cmd_t;

endpackage

// ===== rtl/core/sfr_queue.sv =====
`timescale 1ns / 1ps
// sfr_queue: short command queue between front and back.
// Depends on sfr_pkg.

module sfr_queue
    import sfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

endmodule

// ===== rtl/core/sfr_front.sv =====
`timescale 1ns / 1ps
// sfr_front: accepts beats, holds the presynaptic table, walks the merge
// cursor and issues connection writes and fan-out runs. Depends on sfr_pkg.

module sfr_front
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [12:0] slot,
    input  logic [23:0] neuron_id,
    input  logic [12:0] conn_offset,
    input  logic [15:0] target_synapse,
    input  logic [15:0] delay_steps,
    input  logic [7:0]  spike_step,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_READ = 2'd1;
    localparam logic [1:0] F_CMP  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [OFF_AW-1:0]  cursor_reg, cursor_next;
    logic [ID_BITS-1:0] nid_reg, nid_next;
    logic signed [8:0]  base_reg, base_next;
    logic [10:0]        pre_count_reg;
    logic [7:0]         steps_reg;

    logic [ID_BITS-1:0] ids_mem [MAX_PRE];
    logic [12:0]        offs_mem [MAX_PRE + 1];
    logic [ID_BITS-1:0] id_rd;
    logic [12:0]        lo_rd, hi_rd;

    logic               accept, id_we, off_we, rd_en;
    logic [OFF_AW-1:0]  bound;
    logic [12:0]        end_c, total;
    logic               trunc;

    assign in_stall = (state_reg != F_IDLE) || q_full;
    assign accept   = in_valid && !in_stall;
    assign bound    = (32'(pre_count_reg) > 32'(MAX_PRE)) ? OFF_AW'(MAX_PRE)
                                                          : OFF_AW'(pre_count_reg);
    assign end_c    = (32'(hi_rd) > 32'(MAX_CONN)) ? 13'(MAX_CONN) : hi_rd;
    assign total    = end_c - lo_rd;
    assign trunc    = 32'(total) > 32'(MAX_FANOUT);

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        nid_next    = nid_reg;
        base_next   = base_reg;
        id_we       = 1'b0;
        off_we      = 1'b0;
        rd_en       = 1'b0;
        q_push      = 1'b0;
        q_cmd       = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_LOAD_PRE:
                        begin
                            id_we  = 32'(slot) < 32'(MAX_PRE);
                            off_we = 32'(slot) <= 32'(MAX_PRE);
                        end
                        ACT_LOAD_CONN:
                        begin
                            if (32'(slot) < 32'(MAX_CONN))
                            begin
                                q_push       = 1'b1;
                                q_cmd.kind   = CMD_WRITE;
                                q_cmd.addr   = slot[CONN_AW-1:0];
                                q_cmd.target = target_synapse;
                                q_cmd.delay  = delay_steps;
                            end
                        end
                        ACT_SPIKE:
                        begin
                            if (spike_step != '0)
                            begin
                                nid_next   = neuron_id[ID_BITS-1:0];
                                base_next  = $signed({1'b0, spike_step})
                                           - $signed({1'b0, steps_reg});
                                state_next = F_READ;
                            end
                        end
                        ACT_START:
                        begin
                            cursor_next = '0;
                        end
                        default:
                        begin
                            cursor_next = cursor_reg;
                        end
                    endcase
                end
            end
            F_READ:
            begin
                if (cursor_reg < bound)
                begin
                    rd_en      = 1'b1;
                    state_next = F_CMP;
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            F_CMP:
            begin
                if (id_rd < nid_reg)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    state_next  = F_READ;
                end
                else if (id_rd != nid_reg)
                begin
                    state_next = F_IDLE;
                end
                else if (!(end_c > lo_rd && q_full))
                begin
                    // a matched run waits here while the queue is full
                    cursor_next = cursor_reg + 1'b1;
                    if (end_c > lo_rd)
                    begin
                        q_push      = 1'b1;
                        q_cmd.kind  = CMD_RUN;
                        q_cmd.addr  = lo_rd[CONN_AW-1:0];
                        q_cmd.count = trunc ? FANOUT_W'(MAX_FANOUT)
                                            : total[FANOUT_W-1:0];
                        q_cmd.trunc = trunc;
                        q_cmd.base  = base_reg;
                    end
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            cursor_reg    <= '0;
            pre_count_reg <= 11'd0;
            steps_reg     <= 8'd10;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            if (cfg_we && cfg_index == CFG_PRE_COUNT)
            begin
                pre_count_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_STEPS_PER_MS)
            begin
                steps_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nid_reg  <= nid_next;
        base_reg <= base_next;
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            ids_mem[slot[PRE_AW-1:0]] <= neuron_id[ID_BITS-1:0];
        end
        if (off_we)
        begin
            offs_mem[slot[OFF_AW-1:0]] <= conn_offset;
        end
        if (rd_en)
        begin
            id_rd <= ids_mem[cursor_reg[PRE_AW-1:0]];
            lo_rd <= offs_mem[cursor_reg];
            hi_rd <= offs_mem[cursor_reg + 1'b1];
        end
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_reg) <= 32'(MAX_PRE))
        else $error("merge cursor past table");

    a_read_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_CMP |-> $past(cursor_reg) < $past(bound))
        else $error("table read beyond entry count");

endmodule

// ===== rtl/core/sfr_back.sv =====
`timescale 1ns / 1ps
// sfr_back: owns the connection list and plays out fan-out runs, one
// write beat per cycle unless stalled, into the output register. Depends on sfr_pkg.

module sfr_back
    import sfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        synapse_index,
    output logic signed [17:0] delay_value,
    output logic               last,
    output logic               truncated
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_RUN  = 1'b1;

    logic                state_reg, state_next;
    logic [CONN_AW-1:0]  addr_reg, addr_next;
    logic [FANOUT_W-1:0] remain_reg, remain_next;
    logic                trunc_reg, trunc_next;
    logic signed [8:0]   base_reg, base_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         syn_reg;
    logic signed [17:0]  dval_reg;
    logic                last_reg, trunc_out_reg;

    logic [31:0]         conn_mem [MAX_CONN];
    logic [31:0]         conn_rd;
    logic                mem_we, rd_en, load_out, fin;
    logic [CONN_AW-1:0]  rd_addr;

    assign out_valid     = out_valid_reg;
    assign synapse_index = syn_reg;
    assign delay_value   = dval_reg;
    assign last          = last_reg;
    assign truncated     = trunc_out_reg;
    assign fin           = (remain_reg == FANOUT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        remain_next    = remain_reg;
        trunc_next     = trunc_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = q_cmd.addr;
        load_out       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == CMD_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        addr_next   = q_cmd.addr;
                        remain_next = q_cmd.count;
                        trunc_next  = q_cmd.trunc;
                        base_next   = q_cmd.base;
                        state_next  = B_RUN;
                    end
                end
            end
            B_RUN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    if (fin)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = addr_reg + 1'b1;
                        addr_next   = addr_reg + 1'b1;
                        remain_next = remain_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        remain_reg <= remain_next;
        trunc_reg  <= trunc_next;
        base_reg   <= base_next;
        if (load_out)
        begin
            syn_reg       <= conn_rd[31:16];
            dval_reg      <= $signed({2'b00, conn_rd[15:0]})
                           + $signed({{9{base_reg[8]}}, base_reg});
            last_reg      <= fin;
            trunc_out_reg <= fin && trunc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            conn_mem[q_cmd.addr] <= {q_cmd.target, q_cmd.delay};
        end
        if (rd_en)
        begin
            conn_rd <= conn_mem[rd_addr];
        end
    end

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_RUN |-> remain_reg != '0)
        else $error("fan-out run with no writes left");

    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_cmd.kind == CMD_RUN |-> q_cmd.count != '0)
        else $error("empty fan-out run queued");

endmodule

// ===== rtl/core/spike_fanout_router.sv =====
`timescale 1ns / 1ps
// spike_fanout_router: top level, joins front, command queue and back.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.

// Table and connection loads and start-of-step beats are taken while the front is
// idle. A spike beat with a nonzero step holds the input while the merge cursor
// examines presynaptic entries (each takes a table read and a compare) until it meets
// an equal or larger ID or reaches the entry count, and while a match waits for room
// in the command queue. A match queues a fan-out run that the back end plays out at
// one write beat per cycle, unless the output stalls, from its single-port connection
// memory, while the front takes further beats; the front stalls when the four-entry
// command queue is full. No clearing pass after reset.

module spike_fanout_router
    import sfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [12:0]        slot,
    input  logic [23:0]        neuron_id,
    input  logic [12:0]        conn_offset,
    input  logic [15:0]        target_synapse,
    input  logic [15:0]        delay_steps,
    input  logic [7:0]         spike_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        synapse_index,
    output logic signed [17:0] delay_value,
    output logic               last,
    output logic               truncated
);

    logic q_push, q_pop, q_full, q_empty;
    cmd_t push_cmd, pop_cmd;

    sfr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .slot           (slot),
        .neuron_id      (neuron_id),
        .conn_offset    (conn_offset),
        .target_synapse (target_synapse),
        .delay_steps    (delay_steps),
        .spike_step     (spike_step),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    sfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    sfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .synapse_index (synapse_index),
        .delay_value   (delay_value),
        .last          (last),
        .truncated     (truncated)
    );

endmodule

// ===== tb/sv/tb_spike_fanout_router.sv =====
`timescale 1ns / 1ps
// tb_spike_fanout_router: self-checking bench for spike_fanout_router. Loads
// tables, replays time steps of sorted spikes and checks every write beat.
// Depends on sfr_pkg and spike_fanout_router.

module tb_spike_fanout_router;
    import sfr_pkg::*;

    localparam int DRAIN_CYCLES = 2 * MAX_PRE + 64;
    localparam int WATCHDOG     = 50000;

    typedef struct {
        logic [15:0] syn;
        logic [17:0] dly;
        logic        fin;
        logic        trunc;
    } syn_write_t;

    typedef struct {
        logic [1:0]  action;
        logic [12:0] slot;
        logic [23:0] nid;
        logic [12:0] offs;
        logic [15:0] tgt;
        logic [15:0] dly;
        logic [7:0]  sstep;
    } in_beat_t;

    class route_tracker;
        bit [ID_BITS-1:0] pre_id [MAX_PRE];
        bit [12:0]        pre_off [MAX_PRE+1];
        bit [15:0]        syn_target [MAX_CONN];
        bit [15:0]        syn_delay [MAX_CONN];
        bit               pre_w [MAX_PRE];
        bit               off_w [MAX_PRE+1];
        bit               conn_w [MAX_CONN];
        int unsigned      cursor = 0;
        int unsigned      entry_count = 0;
        bit [7:0]         steps_ms = 8'd10;
        syn_write_t       due_writes [$];
        int               errors = 0;

        // Walks the table without moving the cursor; returns 0 if any entry read is unwritten.
        function bit locate_run(input bit [23:0] nid, output int unsigned stop,
                                output int unsigned first, output int unsigned count,
                                output bit trunc);
            int unsigned bound, c, run_end, total, j;
            bit ok;
            first = 0;
            count = 0;
            trunc = 1'b0;
            bound = (entry_count > MAX_PRE) ? MAX_PRE : entry_count;
            c = cursor;
            while (c < bound) begin
                if (!pre_w[c]) begin
                    stop = c;
                    return 1'b0;
                end
                if (pre_id[c] >= nid[ID_BITS-1:0])
                    break;
                c++;
            end
            stop = c;
            if (c >= bound || pre_id[c] != nid[ID_BITS-1:0])
                return 1'b1;
            ok = off_w[c] && off_w[c+1];
            first = pre_off[c];
            run_end = pre_off[c+1];
            stop = c + 1;
            if (run_end > MAX_CONN)
                run_end = MAX_CONN;
            if (run_end <= first)
                return ok;
            total = run_end - first;
            trunc = total > MAX_FANOUT;
            count = trunc ? MAX_FANOUT : total;
            for (j = first; j < first + count; j++)
                if (!conn_w[j])
                    ok = 1'b0;
            return ok;
        endfunction

        function bit spike_safe(input bit [23:0] nid, input bit [7:0] sstep);
            int unsigned stop, first, count;
            bit trunc;
            if (sstep == 0)
                return 1'b1;
            return locate_run(nid, stop, first, count, trunc);
        endfunction

        function void set_register(input logic [1:0] idx, input int unsigned val);
            if (idx == CFG_PRE_COUNT)
                entry_count = val & 32'h7FF;
            else if (idx == CFG_STEPS_PER_MS)
                steps_ms = val[7:0];
        endfunction

        function void note_beat(input in_beat_t b);
            int unsigned stop, first, count, k;
            bit trunc;
            syn_write_t w;
            case (b.action)
                ACT_LOAD_PRE:
                begin
                    if (b.slot < MAX_PRE)
                    begin
                        pre_id[b.slot] = b.nid[ID_BITS-1:0];
                        pre_w[b.slot] = 1'b1;
                    end
                    if (b.slot <= MAX_PRE)
                    begin
                        pre_off[b.slot] = b.offs;
                        off_w[b.slot] = 1'b1;
                    end
                end
                ACT_LOAD_CONN:
                begin
                    if (b.slot < MAX_CONN)
                    begin
                        syn_target[b.slot] = b.tgt;
                        syn_delay[b.slot] = b.dly;
                        conn_w[b.slot] = 1'b1;
                    end
                end
                ACT_START:
                    cursor = 0;
                default:
                begin
                    if (b.sstep != 0)
                    begin
                        void'(locate_run(b.nid, stop, first, count, trunc));
                        cursor = stop;
                        for (k = 0; k < count; k++)
                        begin
                            w.syn = syn_target[first + k];
                            w.dly = 18'(syn_delay[first + k]) - 18'(steps_ms) + 18'(b.sstep);
                            w.fin = (k + 1 == count);
                            w.trunc = w.fin && trunc;
                            due_writes.push_back(w);
                        end
                    end
                end
            endcase
        endfunction

        function void check_write(input logic [15:0] syn, input logic [17:0] dly,
                                  input logic fin, input logic trunc);
            syn_write_t w;
            if (due_writes.size() == 0)
            begin
                $error("unexpected write beat: synapse_index %0d", syn);
                errors++;
                return;
            end
            w = due_writes.pop_front();
            if (syn !== w.syn)
            begin
                $error("synapse_index: expected %0d, got %0d", w.syn, syn);
                errors++;
            end
            if (dly !== w.dly)
            begin
                $error("delay_value: expected %0d, got %0d", $signed(w.dly), $signed(dly));
                errors++;
            end
            if (fin !== w.fin)
            begin
                $error("last: expected %0d, got %0d", w.fin, fin);
                errors++;
            end
            if (trunc !== w.trunc)
            begin
                $error("truncated: expected %0d, got %0d", w.trunc, trunc);
                errors++;
            end
        endfunction

        function int pending();
            return due_writes.size();
        endfunction

        function void close_out();
            if (due_writes.size() != 0)
            begin
                $error("%0d write beats never arrived", due_writes.size());
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [10:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         action = '0;
    logic [12:0]        slot = '0;
    logic [23:0]        neuron_id = '0;
    logic [12:0]        conn_offset = '0;
    logic [15:0]        target_synapse = '0;
    logic [15:0]        delay_steps = '0;
    logic [7:0]         spike_step = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        synapse_index;
    logic signed [17:0] delay_value;
    logic               last;
    logic               truncated;

    route_tracker routes;
    int feed_mode = 0;
    int drain_mode = 0;
    int stall_left = 0;
    int sent_beats = 0;
    int quiet_cycles = 0;

    spike_fanout_router dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .slot           (slot),
        .neuron_id      (neuron_id),
        .conn_offset    (conn_offset),
        .target_synapse (target_synapse),
        .delay_steps    (delay_steps),
        .spike_step     (spike_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .synapse_index  (synapse_index),
        .delay_value    (delay_value),
        .last           (last),
        .truncated      (truncated)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        return (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_sstep();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 8'd1;
        if (r < 4)
            return 8'd255;
        if (r == 4)
            return 8'd0;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        if (r == 2)
            return 16'($urandom_range(0, 300));
        return 16'($urandom);
    endfunction

    function automatic in_beat_t junk_beat(input logic [1:0] act);
        in_beat_t b;
        b.action = act;
        b.slot = 13'($urandom);
        b.nid = 24'($urandom);
        b.offs = 13'($urandom);
        b.tgt = 16'($urandom);
        b.dly = 16'($urandom);
        b.sstep = 8'($urandom);
        return b;
    endfunction

    // input beat monitor feeds the predictor
    always @(posedge clk)
    begin
        in_beat_t b;
        if (rst_n && in_valid && !in_stall)
        begin
            b.action = action;
            b.slot = slot;
            b.nid = neuron_id;
            b.offs = conn_offset;
            b.tgt = target_synapse;
            b.dly = delay_steps;
            b.sstep = spike_step;
            routes.note_beat(b);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            routes.check_write(synapse_index, delay_value, last, truncated);
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = pick_gap(drain_mode);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG)
                begin
                    $display("tb_spike_fanout_router: errors");
                    $finish;
                end
            end
        end
    end

    task automatic send_beat(input in_beat_t b);
        int gap;
        gap = pick_gap(feed_mode);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        if (b.action == ACT_SPIKE && !routes.spike_safe(b.nid, b.sstep))
        begin
            in_valid <= 1'b0;
            return;
        end
        action <= b.action;
        slot <= b.slot;
        neuron_id <= b.nid;
        conn_offset <= b.offs;
        target_synapse <= b.tgt;
        delay_steps <= b.dly;
        spike_step <= b.sstep;
        in_valid <= 1'b1;
        sent_beats++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic load_pre(input int unsigned s, input int unsigned id, input int unsigned off);
        in_beat_t b;
        b = junk_beat(ACT_LOAD_PRE);
        b.slot = 13'(s);
        b.nid = 24'(id);
        b.offs = 13'(off);
        send_beat(b);
    endtask

    task automatic load_conn(input int unsigned s, input logic [15:0] tgt,
                             input logic [15:0] dly);
        in_beat_t b;
        b = junk_beat(ACT_LOAD_CONN);
        b.slot = 13'(s);
        b.tgt = tgt;
        b.dly = dly;
        send_beat(b);
    endtask

    task automatic spike(input logic [23:0] nid, input logic [7:0] sstep);
        in_beat_t b;
        b = junk_beat(ACT_SPIKE);
        b.nid = nid;
        b.sstep = sstep;
        send_beat(b);
    endtask

    task automatic start_step();
        send_beat(junk_beat(ACT_START));
    endtask

    // loads the block drops: table slots past the end offset, connection slots past the list
    task automatic noise_load();
        if ($urandom_range(0, 1))
            load_pre($urandom_range(MAX_PRE + 1, 4096), $urandom, $urandom_range(0, 4096));
        else
            load_conn(MAX_CONN, pick_word(), pick_word());
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 11'(val);
        @(posedge clk);
        routes.set_register(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // idle the input, wait out pending writes, then hold the input idle for the drain time
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (routes.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int count_reg);
        int unsigned ids [MAX_PRE];
        int unsigned offs [MAX_PRE+1];
        int unsigned len, total, base, span, id, nsteps, step_ms, r;
        int i, s;
        total = 0;
        offs[0] = 0;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 11);
            len = (r == 0) ? $urandom_range(63, 80) : (r < 3) ? 0 : $urandom_range(1, 5);
            total += len;
            offs[i+1] = total;
        end
        base = ($urandom_range(0, 3) == 0) ? MAX_CONN - total : $urandom_range(0, MAX_CONN - total);
        id = $urandom_range(0, 1) ? 0 : $urandom_range(0, 1000);
        span = (32'hFFFFFF - id) / (n + 1);
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
                id += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, span);
            ids[i] = id;
        end
        if ($urandom_range(0, 1))
            ids[n-1] = 32'hFFFFFF;
        r = $urandom_range(0, 3);
        step_ms = (r == 0) ? 1 : (r == 1) ? 255 : $urandom_range(1, 255);

        cfg_write(CFG_PRE_COUNT, count_reg);
        cfg_write(CFG_STEPS_PER_MS, step_ms);
        for (i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 31) == 0)
                noise_load();
            load_conn(base + i, pick_word(), pick_word());
        end
        for (i = 0; i <= n; i++)
            load_pre(i, (i < n) ? ids[i] : $urandom_range(0, 32'hFFFFFF), base + offs[i]);

        nsteps = $urandom_range(2, 5);
        for (s = 0; s < nsteps; s++)
        begin
            start_step();
            for (i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    spike(ids[i], pick_sstep());
                else if (r < 58)
                    spike(24'(ids[i] + 1), pick_sstep());
                else if (r < 61)
                    spike(ids[$urandom_range(0, i)], pick_sstep());
                else if (r < 63)
                    spike(24'($urandom), pick_sstep());
                else if (r < 65)
                    noise_load();
                else if (r < 67 && total > 0)
                    load_conn(base + $urandom_range(0, total - 1), pick_word(), pick_word());
            end
            spike(24'hFFFFFF, pick_sstep());
        end
    endtask

    initial
    begin
        int n;
        int count_reg;
        routes = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table: nothing matches
        cfg_write(CFG_PRE_COUNT, 0);
        spike(24'd0, 8'd5);
        load_conn(0, 16'h0000, 16'h0000);
        load_conn(1, 16'hFFFF, 16'hFFFF);
        load_conn(2, 16'h5A5A, 16'd300);
        load_conn(MAX_CONN, 16'hFFFF, 16'hFFFF);
        load_conn(MAX_CONN - 1, 16'h1234, 16'd7);
        load_pre(0, 24'h000000, 0);
        load_pre(1, 24'h000800, 2);
        load_pre(2, 24'hFFFFFF, 2);
        load_pre(3, 24'h000000, 3);
        load_pre(4096, 24'hFFFFFF, 4096);
        load_pre(2000, 24'h000123, 1);
        load_pre(MAX_PRE, 24'h000000, 4096);
        settle();
        cfg_write(CFG_PRE_COUNT, 3);
        cfg_write(CFG_STEPS_PER_MS, 255);
        start_step();
        spike(24'h000000, 8'd1);
        spike(24'h000800, 8'd0);
        spike(24'h000800, 8'd255);
        spike(24'h000900, 8'd10);
        spike(24'hFFFFFF, 8'd128);
        spike(24'hFFFFFF, 8'd255);
        start_step();
        spike(24'h000005, 8'd7);
        spike(24'h000000, 8'd7);
        spike(24'hFFFFFF, 8'd255);
        settle();

        while (sent_beats < 360)
        begin
            feed_mode = $urandom_range(0, 2);
            drain_mode = $urandom_range(0, 2);
            n = $urandom_range(1, 12);
            count_reg = n;
            // entry counts at and above the table size
            if ($urandom_range(0, 5) == 0)
                count_reg = $urandom_range(0, 1) ? MAX_PRE : 2047;
            run_phase(n, count_reg);
            settle();
        end

        routes.close_out();
        if (routes.errors == 0)
            $display("tb_spike_fanout_router: clean");
        else
            $display("tb_spike_fanout_router: errors");
        $finish;
    end

endmodule
